### rtl/hrms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrms_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/hrms_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hrms_cell
    import hrms_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [DATA_W-1:0] i_x,
    input  wire t_slot                    i_prev,
    input  wire t_slot                    i_next,
    output t_slot                         o_slot
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     w_gt;

    // An empty cell counts as larger than any incoming item.
    assign w_gt   = !r_valid || (r_value > i_x);
    assign o_slot = '{valid: r_valid, gt: w_gt, value: r_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (w_gt) begin
                r_valid <= r_valid | i_prev.valid;
            end
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (w_gt) begin
                if (i_prev.gt) begin
                    r_value <= i_prev.value;
                end else begin
                    r_value <= i_x;
                end
            end
        end else if (i_ctl.shift) begin
            r_value <= i_next.value;
        end
    end

endmodule

`default_nettype wire

### rtl/hybrid_run_merge_sorter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                tlast           tuser
// s side    in   [31:0] value         last of set     -
// m side    out  [31:0] sorted_value  last_res        overflow
//
// Each accepted item is inserted into a sorted chain of CAPACITY cells; if full, it is dropped.
// After the last item, cell 0 drains in ascending order, one item per cycle while m is ready.
// An item dropped when full sets overflow; the input is closed while draining.
// A stall on the output holds the chain; reset empties every cell and returns to loading.

module hybrid_run_merge_sorter_core
    import hrms_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  wire logic              i_s_tlast,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [31:0] sorted_value
    output logic                   o_m_tlast,
    output logic                   o_m_tuser    // [0] overflow
);

    localparam t_slot HEAD_PREV = '{valid: 1'b1, gt: 1'b0, value: '0};
    localparam t_slot TAIL_NEXT = '{valid: 1'b0, gt: 1'b1, value: '0};

    t_state        r_state;
    t_state        n_state;
    logic          r_overflow;
    logic          n_overflow;
    t_cell_ctl     w_ctl;
    t_slot         w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic          w_full;
    logic          w_in_acc;
    logic          w_out_acc;

    assign w_full     = w_slot[CAPACITY-1].valid;
    assign o_s_tready = (r_state == ST_LOAD);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_DRAIN) && w_slot[0].valid;
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = w_slot[0].value;
    assign o_m_tlast  = w_slot[0].valid && !w_slot[1].valid;
    assign o_m_tuser  = r_overflow;

    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.shift = w_out_acc;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_prev;
        t_slot w_next;
        if (g == 0) begin : g_head
            assign w_prev = HEAD_PREV;
        end else begin : g_mid
            assign w_prev = w_slot[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = TAIL_NEXT;
        end else begin : g_body
            assign w_next = w_slot[g+1];
        end
        assign w_valid[g] = w_slot[g].valid;

        hrms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_x     (i_s_tdata),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_slot  (w_slot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_overflow = r_overflow;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && w_full) begin
                    n_overflow = 1'b1;
                end
                if (w_in_acc && i_s_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_m_tlast) begin
                    n_state    = ST_LOAD;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("output valid while input is open");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tlast) |=> o_m_tvalid)
        else $error("no result after the last item of a set");

    a_drain_ends_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_tlast) |=> (o_s_tready && !w_slot[0].valid && !o_m_tuser))
        else $error("chain not empty after the final result");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in the cell chain");

endmodule

`default_nettype wire
